FILE: rtl/core/stfs_pkg.sv
package stfs_pkg;

  localparam int MAX_TASKS = 64;
  localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);
  localparam int KEY_W     = 20;          // {size 3, hour 5, minute 6, second 6}
  localparam int WORD_W    = KEY_W + 1;   // completed mark on top of the key
  localparam int SLOT_W    = 6;

  typedef enum logic [1:0] {
    MODE_APPEND = 2'd0,
    MODE_SELECT = 2'd1,
    MODE_CLEAR  = 2'd2,
    MODE_UNUSED = 2'd3
  } mode_e_t;

  typedef enum logic [2:0] {
    STAT_APPENDED = 3'd0,
    STAT_SELECTED = 3'd1,
    STAT_ALL_DONE = 3'd2,
    STAT_FULL     = 3'd3,
    STAT_CLEARED  = 3'd4
  } status_e_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FIN,
    S_EMIT
  } state_e_t;

  typedef struct packed {
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [2:0] size;
    logic [SLOT_W-1:0] slot;
    status_e_t  status;
  } result_t;

  // Report a table index in the low bits of the slot field.
  function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] idx);
    logic [IDX_W+SLOT_W-1:0] wide;
    wide = {{SLOT_W{1'b0}}, idx};
    return wide[SLOT_W-1:0];
  endfunction

endpackage

FILE: rtl/core/stfs_ram.sv
module stfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/shortest_task_first_selector.sv
// Shortest-task-first selector. Each request on the in_ channel carries a mode
// in in_tuser: append stores a task (size class and arrival time) in the next
// free slot of a 64-entry table, select picks the pending task with the
// smallest size (ties to the earliest arrival, then the lowest slot), marks it
// completed and reports it, and clear empties the table. Every request except
// the unused mode 3 yields exactly one result on the out_ channel, with its
// status in out_tuser. Append and clear place their result in the result
// register and then in the output register. A select walks the table one
// entry per cycle through a single task RAM read port, then passes its result
// through the S_FIN and S_EMIT states to the output register, and the next
// request is taken once the block is back in S_IDLE. A result that cannot
// enter the output register while out_tready is low holds the block.
// The block handles one request at a time but accepts the next one
// while a result still waits in the output register. The table RAM needs no
// clearing pass: each append writes the completed mark along with the task,
// and only slots below the entry count are ever compared.
module shortest_task_first_selector (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [2:0] size_class, [7:3] arrive_hour, [13:8] arrive_minute,
  // [19:14] arrive_second, [23:20] zero
  input  logic [23:0] in_tdata,
  // [1:0] mode
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [5:0] slot, [8:6] chosen_size, [13:9] chosen_hour, [19:14] chosen_minute,
  // [25:20] chosen_second, [31:26] zero
  output logic [31:0] out_tdata,
  // [2:0] status
  output logic [2:0]  out_tuser
);
  import stfs_pkg::*;

  state_e_t state_r, state_nxt;

  logic [CNT_W-1:0]  cnt_r, cnt_nxt;            // entries in use
  logic [CNT_W-1:0]  scan_idx_r, scan_idx_nxt;  // next slot to read
  logic              pend_v_r, pend_v_nxt;      // a read is in flight
  logic [IDX_W-1:0]  pend_slot_r, pend_slot_nxt;
  logic              found_r, found_nxt;
  logic [IDX_W-1:0]  best_slot_r, best_slot_nxt;
  logic [KEY_W-1:0]  best_key_r, best_key_nxt;
  result_t           res_r, res_nxt;            // result waiting for out reg
  logic              out_valid_r, out_valid_nxt;
  result_t           out_res_r, out_res_nxt;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  logic              in_fire;
  logic              out_free;
  mode_e_t           in_mode;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign in_mode   = mode_e_t'(in_tuser);
  assign out_free  = !out_valid_r || out_tready;

  stfs_ram #(
    .WIDTH(WORD_W),
    .DEPTH(MAX_TASKS)
  ) u_task_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    scan_idx_nxt  = scan_idx_r;
    pend_v_nxt    = 1'b0;
    pend_slot_nxt = pend_slot_r;
    found_nxt     = found_r;
    best_slot_nxt = best_slot_r;
    best_key_nxt  = best_key_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_res_nxt   = out_res_r;
    ram_we        = 1'b0;
    ram_waddr     = cnt_r[IDX_W-1:0];
    ram_wdata     = {1'b0, in_tdata[2:0], in_tdata[7:3], in_tdata[13:8], in_tdata[19:14]};
    ram_raddr     = scan_idx_r[IDX_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          res_nxt = '0;
          unique case (in_mode)
            MODE_APPEND: begin
              state_nxt = S_EMIT;
              if (cnt_r >= CNT_W'(MAX_TASKS)) begin
                res_nxt.status = STAT_FULL;
              end else begin
                // store the task with its completed mark cleared
                ram_we         = 1'b1;
                res_nxt.status = STAT_APPENDED;
                res_nxt.slot   = to_slot(cnt_r[IDX_W-1:0]);
                cnt_nxt        = cnt_r + CNT_W'(1);
              end
            end
            MODE_SELECT: begin
              state_nxt    = S_SCAN;
              scan_idx_nxt = '0;
              found_nxt    = 1'b0;
            end
            MODE_CLEAR: begin
              state_nxt      = S_EMIT;
              cnt_nxt        = '0;
              res_nxt.status = STAT_CLEARED;
            end
            default: begin
              // unused mode: drop the request, no result
            end
          endcase
        end
      end

      S_SCAN: begin
        // issue one read per cycle while slots remain
        if (scan_idx_r < cnt_r) begin
          pend_v_nxt    = 1'b1;
          pend_slot_nxt = scan_idx_r[IDX_W-1:0];
          scan_idx_nxt  = scan_idx_r + CNT_W'(1);
        end else if (!pend_v_r) begin
          state_nxt = S_FIN;
        end
        // compare the entry that returns this cycle; strict less keeps ties
        if (pend_v_r && !ram_rdata[WORD_W-1] &&
            (!found_r || (ram_rdata[KEY_W-1:0] < best_key_r))) begin
          found_nxt     = 1'b1;
          best_slot_nxt = pend_slot_r;
          best_key_nxt  = ram_rdata[KEY_W-1:0];
        end
      end

      S_FIN: begin
        state_nxt = S_EMIT;
        res_nxt   = '0;
        if (found_r) begin
          // write back the winner with its completed mark set
          ram_we         = 1'b1;
          ram_waddr      = best_slot_r;
          ram_wdata      = {1'b1, best_key_r};
          res_nxt.status = STAT_SELECTED;
          res_nxt.slot   = to_slot(best_slot_r);
          res_nxt.size   = best_key_r[19:17];
          res_nxt.hour   = best_key_r[16:12];
          res_nxt.minute = best_key_r[11:6];
          res_nxt.second = best_key_r[5:0];
        end else begin
          res_nxt.status = STAT_ALL_DONE;
        end
      end

      S_EMIT: begin
        // hold the result until the output register frees up
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = res_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      pend_v_r    <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_v_r    <= pend_v_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_idx_r  <= scan_idx_nxt;
    pend_slot_r <= pend_slot_nxt;
    best_slot_r <= best_slot_nxt;
    best_key_r  <= best_key_nxt;
    res_r       <= res_nxt;
    out_res_r   <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_res_r.second, out_res_r.minute, out_res_r.hour,
                       out_res_r.size, out_res_r.slot};
  assign out_tuser  = out_res_r.status;

  // The entry count never passes the table depth.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_TASKS))
    else $error("entry count beyond table depth");

  // A winner found during a scan always lies inside the used part of the table.
  a_best_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_SCAN || state_r == S_FIN) && found_r)
      |-> ({1'b0, best_slot_r} < {1'b0, cnt_r}))
    else $error("selected slot outside used entries");

  // A pending result moves to the output register once it is free.
  a_emit_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && out_free) |=> (out_tvalid && state_r == S_IDLE))
    else $error("result not transferred to output");

  // The table RAM is written only by an append or by the write-back of a select.
  a_ram_write_src: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> ((state_r == S_IDLE && in_fire && in_mode == MODE_APPEND) ||
                (state_r == S_FIN && found_r)))
    else $error("unexpected table RAM write");

endmodule

FILE: tb/sv/testbench.sv
module testbench;
  import stfs_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int END_CYCLES  = 80;

  // One expected result: status plus the reported task, all zero where unused.
  typedef struct packed {
    status_e_t         status;
    logic [SLOT_W-1:0] slot;
    logic [2:0]        size;
    logic [4:0]        hour;
    logic [5:0]        minute;
    logic [5:0]        second;
  } outcome_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [2:0]  out_tuser;

  // Shadow copy of the task table; a key orders by size, hour, minute, second.
  logic [19:0] task_key [MAX_TASKS];
  bit          task_done [MAX_TASKS];
  int          tasks_used = 0;

  outcome_t    awaited[$];
  int          mismatches = 0;
  int          cycle_count = 0;
  int          send_gap_pct = 0;
  int          recv_stall_pct = 0;

  shortest_task_first_selector DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Stall the result side at random.
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Update the shadow table for one accepted request and queue its outcome.
  task automatic predict_request(input mode_e_t mode, input logic [19:0] key);
    outcome_t res;
    bit       found;
    int       best;
    res = '0;
    found = 1'b0;
    best = 0;
    case (mode)
      MODE_APPEND: begin
        if (tasks_used >= MAX_TASKS) begin
          res.status = STAT_FULL;
        end else begin
          task_key[tasks_used] = key;
          task_done[tasks_used] = 1'b0;
          res.status = STAT_APPENDED;
          res.slot = tasks_used[SLOT_W-1:0];
          tasks_used++;
        end
        awaited.push_back(res);
      end
      MODE_SELECT: begin
        for (int i = 0; i < tasks_used; i++) begin
          if (!task_done[i] && (!found || task_key[i] < task_key[best])) begin
            found = 1'b1;
            best = i;
          end
        end
        if (!found) begin
          res.status = STAT_ALL_DONE;
        end else begin
          task_done[best] = 1'b1;
          res.status = STAT_SELECTED;
          res.slot = best[SLOT_W-1:0];
          {res.size, res.hour, res.minute, res.second} = task_key[best];
        end
        awaited.push_back(res);
      end
      MODE_CLEAR: begin
        for (int i = 0; i < MAX_TASKS; i++) task_done[i] = 1'b0;
        tasks_used = 0;
        res.status = STAT_CLEARED;
        awaited.push_back(res);
      end
      default: begin
        // unused mode: no result
      end
    endcase
  endtask

  // Present one request from a falling edge and hold it until accepted.
  // Valid stays high on return; callers that stop sending drop it.
  task automatic issue_request(input mode_e_t mode, input logic [2:0] size,
                               input logic [4:0] hour, input logic [5:0] minute,
                               input logic [5:0] second);
    while ($urandom_range(99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {4'b0, second, minute, hour, size};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_request(mode, {size, hour, minute, second});
    @(negedge clk);
  endtask

  // Drop valid and hold off until every queued result has come back.
  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic report_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : check_results
    outcome_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (awaited.size() == 0) begin
        $error("status: expected no result, got %0d", out_tuser);
        mismatches++;
      end else begin
        want = awaited.pop_front();
        report_field("status", want.status, out_tuser);
        report_field("slot", want.slot, out_tdata[5:0]);
        report_field("chosen_size", want.size, out_tdata[8:6]);
        report_field("chosen_hour", want.hour, out_tdata[13:9]);
        report_field("chosen_minute", want.minute, out_tdata[19:14]);
        report_field("chosen_second", want.second, out_tdata[25:20]);
        report_field("padding", 0, out_tdata[31:26]);
      end
    end
  end

  // Field extremes, ties on size and on time, the unused mode, select on an
  // empty table, and clear.
  task automatic test_basic_ordering();
    issue_request(MODE_SELECT, 3'd0, 5'd0, 6'd0, 6'd0);
    issue_request(MODE_UNUSED, 3'd7, 5'd31, 6'd63, 6'd63);
    issue_request(MODE_APPEND, 3'd7, 5'd31, 6'd63, 6'd63);
    issue_request(MODE_APPEND, 3'd0, 5'd0, 6'd0, 6'd0);
    issue_request(MODE_APPEND, 3'd0, 5'd23, 6'd59, 6'd59);
    issue_request(MODE_APPEND, 3'd0, 5'd0, 6'd0, 6'd0);
    issue_request(MODE_APPEND, 3'd2, 5'd10, 6'd30, 6'd15);
    issue_request(MODE_APPEND, 3'd2, 5'd10, 6'd30, 6'd14);
    issue_request(MODE_APPEND, 3'd4, 5'd0, 6'd0, 6'd0);
    issue_request(MODE_APPEND, 3'd5, 5'd16, 6'd32, 6'd32);
    // let the table settle before draining it
    wait_for_results();
    for (int i = 0; i < 9; i++) begin
      issue_request(MODE_SELECT, 3'd0, 5'd0, 6'd0, 6'd0);
      if (i == 0) issue_request(MODE_UNUSED, 3'd0, 5'd0, 6'd0, 6'd0);
    end
    issue_request(MODE_CLEAR, 3'd7, 5'd31, 6'd63, 6'd63);
    issue_request(MODE_SELECT, 3'd0, 5'd0, 6'd0, 6'd0);
    issue_request(MODE_APPEND, 3'd1, 5'd12, 6'd0, 6'd59);
    issue_request(MODE_SELECT, 3'd0, 5'd0, 6'd0, 6'd0);
    issue_request(MODE_CLEAR, 3'd0, 5'd0, 6'd0, 6'd0);
  endtask

  // Fill the table, overflow it, select every entry and overflow it again.
  task automatic test_full_table();
    issue_request(MODE_CLEAR, 3'd0, 5'd0, 6'd0, 6'd0);
    for (int i = 0; i < MAX_TASKS + 2; i++) begin
      issue_request(MODE_APPEND, 3'($urandom_range(4)), 5'($urandom_range(3)),
                    6'($urandom_range(59)), 6'($urandom_range(59)));
    end
    for (int i = 0; i < MAX_TASKS + 1; i++) begin
      issue_request(MODE_SELECT, 3'd0, 5'd0, 6'd0, 6'd0);
    end
    issue_request(MODE_APPEND, 3'd1, 5'd1, 6'd1, 6'd1);
    issue_request(MODE_CLEAR, 3'd0, 5'd0, 6'd0, 6'd0);
  endtask

  // Mostly appends and selects on a small table; clears and unused modes now
  // and then. A share of the times sits in a tiny range to force ties.
  task automatic test_random_traffic(input int requests, input int gap, input int stall);
    int          counted;
    int          pick;
    int          shape;
    logic [2:0]  sz;
    logic [4:0]  hr;
    logic [5:0]  mi;
    logic [5:0]  se;
    counted = 0;
    send_gap_pct = gap;
    recv_stall_pct = stall;
    while (counted < requests) begin
      pick = $urandom_range(99);
      shape = $urandom_range(9);
      if (shape < 3) begin
        sz = 3'($urandom_range(1));
        hr = 5'($urandom_range(1));
        mi = 6'($urandom_range(1));
        se = 6'($urandom_range(1));
      end else if (shape == 3) begin
        sz = 3'($urandom_range(7));
        hr = 5'($urandom_range(31));
        mi = 6'($urandom_range(63));
        se = 6'($urandom_range(63));
      end else begin
        sz = 3'($urandom_range(4));
        hr = 5'($urandom_range(23));
        mi = 6'($urandom_range(59));
        se = 6'($urandom_range(59));
      end
      if (pick < 3) begin
        issue_request(MODE_UNUSED, sz, hr, mi, se);
      end else begin
        if (pick < 7) issue_request(MODE_CLEAR, sz, hr, mi, se);
        else if (pick < 57) issue_request(MODE_APPEND, sz, hr, mi, se);
        else issue_request(MODE_SELECT, sz, hr, mi, se);
        counted++;
      end
    end
  endtask

  initial begin
    send_gap_pct = 28;
    recv_stall_pct = 61;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_basic_ordering();
    test_full_table();
    test_random_traffic(140, 28, 61);
    test_random_traffic(140, 61, 28);
    test_random_traffic(140, 0, 0);

    wait_for_results();
    repeat (END_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/stfs_pkg.sv
rtl/core/stfs_ram.sv
rtl/core/shortest_task_first_selector.sv
tb/sv/testbench.sv
